[rtl/vhgs_pkg.sv]
package vhgs_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_FLAG   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELOAD_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ON_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HYST_DELTA   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_MASK  = 3'd4;

	localparam logic [7:0]         FORCE_ON_VALUE  = 8'd1;
	localparam logic [7:0]         STATUS_ON_VALUE = 8'd1;
	localparam logic [7:0]         MODE_ZERO       = 8'd0;
	localparam logic [7:0]         MODE_ONE        = 8'd1;
	localparam logic [15:0]        RELOAD_RESET    = 16'd188;
	localparam logic signed [15:0] ON_RESET        = 16'sd3200;
	localparam logic signed [15:0] DELTA_RESET     = -16'sd48;
	localparam logic [7:0]         MASK_RESET      = 8'hFF;

	localparam logic [15:0] MAGIC_VALID = 16'hE926;
	localparam logic [7:0]  LATCH_COUNT = 8'd7;
	localparam logic [7:0]  CELL_HOLD_A = 8'd5;
	localparam logic [7:0]  CELL_HOLD_B = 8'd7;
	localparam logic [7:0]  LATCH_ONE   = 8'd1;

	typedef struct packed {
		logic        step;
		logic        en;
		logic [7:0]  masked;
		logic [15:0] magic;
		logic [15:0] src;
		logic [7:0]  cnt;
	} sens_req_t;

endpackage

[rtl/vhgs_if.sv]
interface vhgs_tick_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temperature;
	logic [7:0]         mode;
	logic [7:0]         status_byte;
	logic [7:0]         sensor_input;
	logic [15:0]        magic_word;
	logic [15:0]        source_word;
	logic [7:0]         count_byte;

	modport source (output valid, temperature, mode, status_byte, sensor_input,
		magic_word, source_word, count_byte, input ready);
	modport sink (input valid, temperature, mode, status_byte, sensor_input,
		magic_word, source_word, count_byte, output ready);
endinterface

interface vhgs_report_if;
	logic        valid;
	logic        ready;
	logic [7:0]  machine_result;
	logic        status_bit;
	logic        valve_command;
	logic [15:0] counter_value;
	logic        enable_bit;

	modport source (output valid, machine_result, status_bit, valve_command,
		counter_value, enable_bit, input ready);
	modport sink (input valid, machine_result, status_bit, valve_command,
		counter_value, enable_bit, output ready);
endinterface

[rtl/valve_hysteresis_gate_sequencer.sv]
// One control tick in, one report out. A tick is captured in an input register and,
// when the report register is free or draining, runs through the hysteresis compare,
// the transition counter, the enable gate and the sensor machine into the report
// register, updating the block state at the same edge. A new tick is taken every
// cycle while the report side keeps draining, and a stalled report holds one tick
// in the input register before ready drops.
// Configuration writes land immediately and must only be issued while idle.
module valve_hysteresis_gate_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vhgs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [vhgs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	vhgs_tick_if.sink                       tick,
	vhgs_report_if.source                   report
);
	import vhgs_pkg::*;

	logic [7:0]         force_flag_q;
	logic [15:0]        reload_count_q;
	logic signed [15:0] on_threshold_q;
	logic signed [15:0] hyst_delta_q;
	logic [7:0]         sensor_mask_q;

	logic               valid_s1;
	logic signed [15:0] temperature_s1;
	logic [7:0]         mode_s1;
	logic [7:0]         status_s1;
	logic [7:0]         sensor_s1;
	logic [15:0]        magic_s1;
	logic [15:0]        source_s1;
	logic [7:0]         count_s1;

	logic        command_q;
	logic [15:0] counter_q;
	logic        prev_mode_one_q;

	logic        rep_valid_q;
	logic [7:0]  rep_result_q;
	logic        rep_status_q;
	logic        rep_command_q;
	logic [15:0] rep_counter_q;
	logic        rep_enable_q;

	logic               advance;
	logic               step;
	logic signed [16:0] off_threshold;
	logic               command_n;
	logic [15:0]        counter_n;
	logic               enable;
	sens_req_t          sens_req;
	logic [7:0]         sens_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_flag_q   <= 8'd0;
			reload_count_q <= RELOAD_RESET;
			on_threshold_q <= ON_RESET;
			hyst_delta_q   <= DELTA_RESET;
			sensor_mask_q  <= MASK_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_FORCE_FLAG)   force_flag_q   <= cfg_wdata[7:0];
			if (cfg_idx == CFG_RELOAD_COUNT) reload_count_q <= cfg_wdata;
			if (cfg_idx == CFG_ON_THRESHOLD) on_threshold_q <= signed'(cfg_wdata);
			if (cfg_idx == CFG_HYST_DELTA)   hyst_delta_q   <= signed'(cfg_wdata);
			if (cfg_idx == CFG_SENSOR_MASK)  sensor_mask_q  <= cfg_wdata[7:0];
		end
	end

	assign advance    = !rep_valid_q || report.ready;
	assign step       = valid_s1 && advance;
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.valid && tick.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			temperature_s1 <= tick.temperature;
			mode_s1        <= tick.mode;
			status_s1      <= tick.status_byte;
			sensor_s1      <= tick.sensor_input;
			magic_s1       <= tick.magic_word;
			source_s1      <= tick.source_word;
			count_s1       <= tick.count_byte;
		end
	end

	always_comb begin
		off_threshold = 17'(on_threshold_q) + 17'(hyst_delta_q);
		if (temperature_s1 >= on_threshold_q) begin
			command_n = 1'b1;
		end else if (17'(temperature_s1) < off_threshold) begin
			command_n = 1'b0;
		end else begin
			command_n = command_q;
		end
		if (mode_s1 == MODE_ZERO && prev_mode_one_q) begin
			counter_n = reload_count_q;
		end else if (counter_q != 16'd0) begin
			counter_n = counter_q - 16'd1;
		end else begin
			counter_n = counter_q;
		end
		enable = (force_flag_q == FORCE_ON_VALUE) || (status_s1 == STATUS_ON_VALUE) ||
			(mode_s1 == MODE_ZERO && counter_n != 16'd0 && !command_n);
	end

	assign sens_req = '{
		step:   step,
		en:     enable,
		masked: sensor_s1 & sensor_mask_q,
		magic:  magic_s1,
		src:    source_s1,
		cnt:    count_s1
	};

	vhgs_sensor u_sensor (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sens_req),
		.result (sens_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q       <= 1'b0;
			counter_q       <= 16'd0;
			prev_mode_one_q <= 1'b0;
			rep_valid_q     <= 1'b0;
		end else begin
			if (step) begin
				command_q       <= command_n;
				counter_q       <= counter_n;
				prev_mode_one_q <= (mode_s1 == MODE_ONE);
				rep_valid_q     <= 1'b1;
			end else if (report.ready) begin
				rep_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rep_result_q  <= sens_result;
			rep_status_q  <= (sens_result == 8'd1);
			rep_command_q <= command_n;
			rep_counter_q <= counter_n;
			rep_enable_q  <= enable;
		end
	end

	assign report.valid          = rep_valid_q;
	assign report.machine_result = rep_result_q;
	assign report.status_bit     = rep_status_q;
	assign report.valve_command  = rep_command_q;
	assign report.counter_value  = rep_counter_q;
	assign report.enable_bit     = rep_enable_q;

endmodule

[rtl/vhgs_sensor.sv]
module vhgs_sensor (
	input  logic                clk,
	input  logic                arst_n,
	input  vhgs_pkg::sens_req_t req,
	output logic [7:0]          result
);
	import vhgs_pkg::*;

	logic       armed_q, armed_n;
	logic [7:0] latch_q, latch_n;
	logic [7:0] cell_q, cell_n;

	always_comb begin
		armed_n = armed_q;
		latch_n = latch_q;
		cell_n  = cell_q;
		if (!armed_q) begin
			if (req.magic == MAGIC_VALID) begin
				armed_n = 1'b1;
				if (req.masked != 8'd0) begin
					cell_n = req.cnt;
					if (req.cnt == LATCH_COUNT) begin
						latch_n = req.src[15:8];
					end
				end else begin
					cell_n = 8'd0;
				end
			end else if (req.masked == 8'd0) begin
				cell_n = 8'd0;
			end
		end
		if (cell_n == 8'd0) begin
			latch_n = {7'd0, req.en};
			result  = {7'd0, req.en};
		end else if (cell_n == CELL_HOLD_A || cell_n == CELL_HOLD_B) begin
			result = {7'd0, latch_n == LATCH_ONE};
		end else begin
			result = {7'd0, req.en};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			latch_q <= 8'd0;
			cell_q  <= 8'd0;
		end else if (req.step) begin
			armed_q <= armed_n;
			latch_q <= latch_n;
			cell_q  <= cell_n;
		end
	end

endmodule

[verif/vhgs_report_checker.sv]
`timescale 1ns / 1ps

module vhgs_report_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vhgs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [vhgs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	vhgs_tick_if                            tick,
	vhgs_report_if                          report,
	output int                              mismatches,
	output int                              outstanding
);
	import vhgs_pkg::*;

	localparam logic [7:0] SENS_IDLE  = 8'd0;
	localparam logic [7:0] SENS_ARMED = 8'd1;
	localparam logic [7:0] SENS_EMPTY = 8'd2;

	typedef struct packed {
		logic [7:0]  machine_result;
		logic        status_bit;
		logic        valve_command;
		logic [15:0] counter_value;
		logic        enable_bit;
	} report_t;

	logic [7:0]         force_val;
	logic [15:0]        reload_val;
	logic signed [15:0] on_thr;
	logic signed [15:0] hyst_delta;
	logic [7:0]         mask_val;

	logic        valve_cmd;
	logic [15:0] trans_cnt;
	logic [7:0]  last_mode;
	logic [7:0]  sens_state;
	logic [7:0]  out_latch;
	logic [7:0]  out_cell;

	report_t expected_reports[$];

	task automatic advance_valve_state(
		input  logic signed [15:0] temp,
		input  logic [7:0]         mode,
		input  logic [7:0]         status,
		input  logic [7:0]         sens_in,
		input  logic [15:0]        magic,
		input  logic [15:0]        src,
		input  logic [7:0]         cnt,
		output report_t            rep
	);
		logic signed [16:0] off_lvl;
		logic [7:0]         masked;
		logic               en;
		logic [7:0]         res;
		off_lvl = on_thr + hyst_delta;
		if (temp >= on_thr)
			valve_cmd = 1'b1;
		else if (temp < off_lvl)
			valve_cmd = 1'b0;

		if (mode == MODE_ZERO && last_mode == MODE_ONE)
			trans_cnt = reload_val;
		else if (trans_cnt != 16'd0)
			trans_cnt = trans_cnt - 16'd1;

		en = (force_val == FORCE_ON_VALUE) || (status == STATUS_ON_VALUE) ||
			(mode == MODE_ZERO && trans_cnt != 16'd0 && !valve_cmd);

		masked = sens_in & mask_val;
		if (sens_state == SENS_IDLE) begin
			if (magic == MAGIC_VALID) begin
				if (masked != 8'd0) begin
					out_cell = cnt;
					if (cnt == LATCH_COUNT)
						out_latch = src[15:8];
					sens_state = SENS_ARMED;
				end else begin
					out_cell = 8'd0;
					sens_state = SENS_EMPTY;
				end
			end else if (masked == 8'd0) begin
				out_cell = 8'd0;
			end
		end

		if (out_cell == 8'd0) begin
			out_latch = {7'd0, en};
			res = {7'd0, en};
		end else if (out_cell == CELL_HOLD_A || out_cell == CELL_HOLD_B) begin
			res = (out_latch == LATCH_ONE) ? 8'd1 : 8'd0;
		end else begin
			res = {7'd0, en};
		end

		last_mode = mode;

		rep.machine_result = res;
		rep.status_bit     = (res == 8'd1);
		rep.valve_command  = valve_cmd;
		rep.counter_value  = trans_cnt;
		rep.enable_bit     = en;
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t got;
		report_t want;
		if (!arst_n) begin
			force_val  = 8'd0;
			reload_val = RELOAD_RESET;
			on_thr     = ON_RESET;
			hyst_delta = DELTA_RESET;
			mask_val   = MASK_RESET;
			valve_cmd  = 1'b0;
			trans_cnt  = 16'd0;
			last_mode  = 8'd0;
			sens_state = SENS_IDLE;
			out_latch  = 8'd0;
			out_cell   = 8'd0;
			expected_reports.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_FORCE_FLAG:   force_val  = cfg_wdata[7:0];
					CFG_RELOAD_COUNT: reload_val = cfg_wdata;
					CFG_ON_THRESHOLD: on_thr     = cfg_wdata;
					CFG_HYST_DELTA:   hyst_delta = cfg_wdata;
					CFG_SENSOR_MASK:  mask_val   = cfg_wdata[7:0];
					default: ;
				endcase
			end

			if (report.valid && report.ready) begin
				got.machine_result = report.machine_result;
				got.status_bit     = report.status_bit;
				got.valve_command  = report.valve_command;
				got.counter_value  = report.counter_value;
				got.enable_bit     = report.enable_bit;
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: report transfer with none expected: res=%0d st=%0d cmd=%0d cnt=%0d en=%0d",
							$realtime, got.machine_result, got.status_bit, got.valve_command,
							got.counter_value, got.enable_bit);
				end else begin
					want = expected_reports.pop_front();
					if (got.machine_result !== want.machine_result ||
						got.status_bit !== want.status_bit ||
						got.valve_command !== want.valve_command ||
						got.counter_value !== want.counter_value ||
						got.enable_bit !== want.enable_bit) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: report mismatch exp res=%0d st=%0d cmd=%0d cnt=%0d en=%0d got res=%0d st=%0d cmd=%0d cnt=%0d en=%0d",
								$realtime, want.machine_result, want.status_bit,
								want.valve_command, want.counter_value, want.enable_bit,
								got.machine_result, got.status_bit, got.valve_command,
								got.counter_value, got.enable_bit);
					end
				end
			end

			if (tick.valid && tick.ready) begin
				advance_valve_state(tick.temperature, tick.mode, tick.status_byte,
					tick.sensor_input, tick.magic_word, tick.source_word, tick.count_byte, want);
				expected_reports.push_back(want);
			end

			outstanding = expected_reports.size();
		end
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import vhgs_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int mismatches;
	int outstanding;
	int idle_pct;
	int stall_pct;
	int hold_left;

	logic signed [15:0] cur_on;
	logic signed [15:0] cur_delta;

	vhgs_tick_if   tick_ch ();
	vhgs_report_if report_ch ();

	valve_hysteresis_gate_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.tick      (tick_ch),
		.report    (report_ch)
	);

	vhgs_report_checker report_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.tick        (tick_ch),
		.report      (report_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL valve_hysteresis_gate_sequencer");
		$finish;
	end

	// hold off for the requested stretch, else stall at random
	initial begin
		report_ch.ready = 1'b0;
		forever @(negedge clk) begin
			if (hold_left > 0) begin
				report_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				report_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_tick(
		input logic signed [15:0] temp,
		input logic [7:0]         mode,
		input logic [7:0]         status,
		input logic [7:0]         sens_in,
		input logic [15:0]        magic,
		input logic [15:0]        src,
		input logic [7:0]         cnt
	);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		tick_ch.valid        <= 1'b1;
		tick_ch.temperature  <= temp;
		tick_ch.mode         <= mode;
		tick_ch.status_byte  <= status;
		tick_ch.sensor_input <= sens_in;
		tick_ch.magic_word   <= magic;
		tick_ch.source_word  <= src;
		tick_ch.count_byte   <= cnt;
		do @(posedge clk); while (!tick_ch.ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic random_tick();
		int                 r;
		int                 t;
		int                 off_lvl;
		logic [7:0]         mode;
		logic [7:0]         status;
		logic [7:0]         sens_in;
		logic [15:0]        magic;
		logic [7:0]         cnt;
		off_lvl = int'(cur_on) + int'(cur_delta);
		r = $urandom_range(99);
		if (r < 35)
			t = int'(cur_on) + int'($urandom_range(8)) - 4;
		else if (r < 70)
			t = off_lvl + int'($urandom_range(8)) - 4;
		else if (r < 80)
			t = $urandom_range(1) ? 32767 : -32768;
		else
			t = int'($signed(16'($urandom)));
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;

		r = $urandom_range(99);
		if (r < 45) mode = MODE_ZERO;
		else if (r < 85) mode = MODE_ONE;
		else mode = 8'($urandom);

		status  = ($urandom_range(99) < 20) ? STATUS_ON_VALUE : 8'($urandom);
		sens_in = ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom);
		magic   = ($urandom_range(99) < 10) ? MAGIC_VALID : 16'($urandom);
		r = $urandom_range(99);
		if (r < 30) cnt = LATCH_COUNT;
		else if (r < 50) cnt = CELL_HOLD_A;
		else cnt = 8'($urandom);

		send_tick(16'(t), mode, status, sens_in, magic, 16'($urandom), cnt);
	endtask

	task automatic run_phase(
		input logic [7:0]         force_val,
		input logic [15:0]        reload_val,
		input logic signed [15:0] on_val,
		input logic signed [15:0] delta_val,
		input logic [7:0]         mask_val,
		input int                 idle_val,
		input int                 stall_val,
		input int                 count,
		input int                 hold_val
	);
		wait_idle();
		write_reg(CFG_FORCE_FLAG, {8'd0, force_val});
		write_reg(CFG_RELOAD_COUNT, reload_val);
		write_reg(CFG_ON_THRESHOLD, on_val);
		write_reg(CFG_HYST_DELTA, delta_val);
		write_reg(CFG_SENSOR_MASK, {8'd0, mask_val});
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_on    = on_val;
		cur_delta = delta_val;
		idle_pct  = idle_val;
		stall_pct = stall_val;
		for (int i = 0; i < count; i++) begin
			if (i == 20 && hold_val > 0)
				hold_left = hold_val;
			random_tick();
		end
	endtask

	initial begin
		int          r;
		logic [7:0]  sens_in;
		logic [15:0] src;
		logic [7:0]  cnt;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = '0;
		cfg_wdata = '0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_left = 0;
		cur_on    = ON_RESET;
		cur_delta = DELTA_RESET;
		tick_ch.valid        = 1'b0;
		tick_ch.temperature  = '0;
		tick_ch.mode         = '0;
		tick_ch.status_byte  = '0;
		tick_ch.sensor_input = '0;
		tick_ch.magic_word   = '0;
		tick_ch.source_word  = '0;
		tick_ch.count_byte   = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_tick(16'h8000, MODE_ZERO, 8'd0, 8'h00, 16'h0000, 16'h0000, 8'h00);
		send_tick(16'h7FFF, MODE_ONE, STATUS_ON_VALUE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_tick(ON_RESET, MODE_ZERO, 8'd0, 8'h01, 16'h0000, 16'h0000, 8'd7);
		send_tick(ON_RESET - 16'sd1, MODE_ZERO, 8'd0, 8'h00, 16'h1234, 16'h0100, 8'd5);
		send_tick(ON_RESET + DELTA_RESET, MODE_ZERO, 8'd0, 8'h10, 16'hE927, 16'h0000, 8'd0);
		send_tick(ON_RESET + DELTA_RESET - 16'sd1, MODE_ZERO, 8'd0, 8'h00, 16'h0000,
			16'h0000, 8'd0);
		send_tick(16'h0000, 8'd2, 8'd2, 8'h80, 16'h6926, 16'h8000, 8'd5);
		send_tick(16'h0000, 8'hFF, 8'hFF, 8'h00, 16'hE906, 16'h00FF, 8'd7);
		send_tick(16'h0000, MODE_ONE, STATUS_ON_VALUE, 8'h00, 16'h0000, 16'h0000, 8'd0);
		send_tick(16'h0000, MODE_ZERO, 8'd0, 8'h00, 16'h0000, 16'h0000, 8'd0);
		send_tick(16'h0C80, MODE_ZERO, 8'd0, 8'h55, 16'hAAAA, 16'h5555, 8'hAA);
		send_tick(16'hFFFF, MODE_ZERO, 8'd0, 8'hAA, 16'h5555, 16'hAAAA, 8'h55);

		// leave the idle sensor state once, with a seed-chosen cell value
		r = $urandom_range(99);
		sens_in = 8'h81;
		src = 16'($urandom);
		cnt = 8'($urandom);
		if (r < 40) begin
			cnt = LATCH_COUNT;
			src = {LATCH_ONE, 8'($urandom)};
		end else if (r < 55) begin
			cnt = LATCH_COUNT;
		end else if (r < 70) begin
			cnt = CELL_HOLD_A;
		end else if (r < 85) begin
			sens_in = 8'h00;
		end
		send_tick(16'h0000, MODE_ONE, STATUS_ON_VALUE, sens_in, MAGIC_VALID, src, cnt);
		send_tick(16'h0000, MODE_ZERO, 8'd0, 8'h00, MAGIC_VALID, 16'h0700, LATCH_COUNT);
		send_tick(16'h7FFF, MODE_ZERO, 8'd0, 8'hFF, MAGIC_VALID, 16'h0100, CELL_HOLD_A);
		send_tick(16'h8000, MODE_ONE, STATUS_ON_VALUE, 8'h01, 16'h0000, 16'hFFFF, 8'd1);
		send_tick(16'h8000, MODE_ZERO, 8'd0, 8'h00, 16'h0000, 16'h0000, 8'd0);

		run_phase(8'd0, RELOAD_RESET, ON_RESET, DELTA_RESET, MASK_RESET, 0, 0, 150, 0);
		run_phase(8'd0, 16'd3, 16'sd0, -16'sd16, 8'h0F, 53, 0, 200, 0);
		run_phase(FORCE_ON_VALUE, 16'hFFFF, 16'h8000, 16'h8000, 8'h00, 0, 53, 150, 0);
		run_phase(8'hFF, 16'd0, 16'h7FFF, 16'h7FFF, 8'hFF, 14, 14, 150, 0);
		run_phase(8'd0, 16'd20, 16'sd100, 16'sd64, 8'hA5, 0, 0, 200, 80);
		run_phase(8'd0, RELOAD_RESET, -16'sd5, 16'h8000, 8'h01, 14, 14, 200, 0);
		run_phase(8'd2, 16'd7, 16'h7FFF, 16'h8000, 8'h80, 53, 53, 200, 0);

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS valve_hysteresis_gate_sequencer");
		else
			$display("FAIL valve_hysteresis_gate_sequencer");
		$finish;
	end

endmodule

[filelist.f]
rtl/vhgs_pkg.sv
rtl/vhgs_if.sv
rtl/vhgs_sensor.sv
rtl/valve_hysteresis_gate_sequencer.sv
verif/vhgs_report_checker.sv
verif/testbench.sv
